/* rtl/core/svpwm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types and constants for the SVPWM sector decoder and dwell unit.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  // Angle and percentage constants
  localparam logic [9:0] FullTurn    = 10'd360;
  localparam logic [9:0] TwoTurns    = 10'd720;
  localparam logic [6:0] FullPct     = 7'd100;

  // Vector codes
  localparam logic [2:0] VEC_NONE        = 3'd0;
  localparam logic [2:0] VEC_ZERO        = 3'd1;
  localparam logic [2:0] VEC_ACTIVE_BASE = 3'd2;

  // Sector codes between vectors start here
  localparam logic [3:0] SECTOR_BASE     = 4'd6;

  // floor(x/100) as (x * DivMul) >> DivShift, exact for x below 40000
  localparam logic [12:0] DivMul   = 13'd5243;
  localparam int          DivShift = 19;

  // Rounded share of the sector in percent: round(d*100/60), half up
  localparam logic [6:0] DWELL_PCT [0:59] = '{
    7'd0,  7'd2,  7'd3,  7'd5,  7'd7,  7'd8,
    7'd10, 7'd12, 7'd13, 7'd15, 7'd17, 7'd18,
    7'd20, 7'd22, 7'd23, 7'd25, 7'd27, 7'd28,
    7'd30, 7'd32, 7'd33, 7'd35, 7'd37, 7'd38,
    7'd40, 7'd42, 7'd43, 7'd45, 7'd47, 7'd48,
    7'd50, 7'd52, 7'd53, 7'd55, 7'd57, 7'd58,
    7'd60, 7'd62, 7'd63, 7'd65, 7'd67, 7'd68,
    7'd70, 7'd72, 7'd73, 7'd75, 7'd77, 7'd78,
    7'd80, 7'd82, 7'd83, 7'd85, 7'd87, 7'd88,
    7'd90, 7'd92, 7'd93, 7'd95, 7'd97, 7'd98
  };

  // Decoded item between the decode and duty stages
  typedef struct packed {
    logic [3:0]  sector_code;
    logic [2:0]  first_vector;
    logic [2:0]  second_vector;
    logic [2:0]  third_vector;
    logic [6:0]  mag;
    logic [13:0] prod;
  } mid_t;

  // Finished result beat
  typedef struct packed {
    logic [3:0] sector_code;
    logic [2:0] first_vector;
    logic [2:0] second_vector;
    logic [2:0] third_vector;
    logic [6:0] duty_first;
    logic [6:0] duty_second;
    logic [6:0] duty_zero;
  } res_t;

endpackage
`default_nettype wire

/* rtl/core/svpwm_decode.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_decode
// Reduces the angle, finds the vector or sector, picks the vectors and forms
// the product of the rounded sector share and the saturated magnitude.
// ----------------------------------------------------------------------------
module svpwm_decode (
  input  wire logic [9:0]     angle_deg,
  input  wire logic [6:0]     magnitude_pct,
  output svpwm_pkg::mid_t     mid
);

  logic [9:0] ang_red;
  logic [8:0] ang;
  logic [2:0] pos;
  logic [8:0] base;
  logic [8:0] diff;
  logic [5:0] d;
  logic       on_vec;
  logic [6:0] mag;
  logic [6:0] pct;
  logic [2:0] pos_next;

  // Fold the angle into 0..359 (360 maps onto U+)
  always_comb begin
    if (angle_deg > svpwm_pkg::TwoTurns) begin
      ang_red = angle_deg - svpwm_pkg::TwoTurns;
    end else if (angle_deg > svpwm_pkg::FullTurn) begin
      ang_red = angle_deg - svpwm_pkg::FullTurn;
    end else begin
      ang_red = angle_deg;
    end
    ang = (ang_red == svpwm_pkg::FullTurn) ? 9'd0 : ang_red[8:0];
  end

  // Find the 60-degree slot and the offset within it
  always_comb begin
    if (ang >= 9'd300) begin
      pos = 3'd5; base = 9'd300;
    end else if (ang >= 9'd240) begin
      pos = 3'd4; base = 9'd240;
    end else if (ang >= 9'd180) begin
      pos = 3'd3; base = 9'd180;
    end else if (ang >= 9'd120) begin
      pos = 3'd2; base = 9'd120;
    end else if (ang >= 9'd60) begin
      pos = 3'd1; base = 9'd60;
    end else begin
      pos = 3'd0; base = 9'd0;
    end
    diff   = ang - base;
    d      = diff[5:0];
    on_vec = (d == 6'd0);
  end

  // Saturate magnitude and look up the rounded share
  assign mag      = (magnitude_pct > svpwm_pkg::FullPct) ? svpwm_pkg::FullPct : magnitude_pct;
  assign pct      = svpwm_pkg::DWELL_PCT[d];
  assign pos_next = (pos == 3'd5) ? 3'd0 : pos + 3'd1;

  // Assemble the decoded item
  always_comb begin
    mid.first_vector  = svpwm_pkg::VEC_ACTIVE_BASE + pos;
    mid.third_vector  = (mag < svpwm_pkg::FullPct) ? svpwm_pkg::VEC_ZERO : svpwm_pkg::VEC_NONE;
    mid.mag           = mag;
    mid.prod          = 14'(pct) * 14'(mag);
    if (on_vec) begin
      mid.sector_code   = {1'b0, pos};
      mid.second_vector = svpwm_pkg::VEC_NONE;
    end else begin
      mid.sector_code   = svpwm_pkg::SECTOR_BASE + {1'b0, pos};
      mid.second_vector = svpwm_pkg::VEC_ACTIVE_BASE + pos_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/svpwm_duty.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_duty
// Scales the share-times-magnitude product down by 100 and splits the
// period into first, second and zero vector duties.
// ----------------------------------------------------------------------------
module svpwm_duty (
  input  wire svpwm_pkg::mid_t mid,
  output svpwm_pkg::res_t      res
);

  logic [26:0] scaled;
  logic [6:0]  second;

  // Divide by 100 through a reciprocal multiply
  assign scaled = 27'(mid.prod) * 27'(svpwm_pkg::DivMul);
  assign second = scaled[svpwm_pkg::DivShift +: 7];

  // Split the period
  always_comb begin
    res.sector_code   = mid.sector_code;
    res.first_vector  = mid.first_vector;
    res.second_vector = mid.second_vector;
    res.third_vector  = mid.third_vector;
    res.duty_second   = second;
    res.duty_first    = mid.mag - second;
    res.duty_zero     = svpwm_pkg::FullPct - mid.mag;
  end

endmodule
`default_nettype wire

/* rtl/core/svpwm_sector_and_duty_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_sector_and_duty_unit
// Two-level space-vector PWM sector decoder and dwell calculator.
// ----------------------------------------------------------------------------
// Takes one beat per clock while in_ready is high: a new angle/magnitude
// pair can enter every such cycle, and each result is presented once the
// beat has passed the input, decode and result registers. The
// decode stage holds the angle fold, the share lookup and a 7x7 multiply;
// the duty stage holds the reciprocal multiply that divides by 100, so each
// stage carries one multiplier. Every stage has its own valid bit and
// stalls only when the stage after it is full and blocked, so a result
// waiting on out_ready does not stop new beats from filling empty stages.
module svpwm_sector_and_duty_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [9:0] in_angle_deg,
  input  wire logic [6:0] in_magnitude_pct,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      out_sector_code,
  output logic [2:0]      out_first_vector,
  output logic [2:0]      out_second_vector,
  output logic [2:0]      out_third_vector,
  output logic [6:0]      out_duty_first,
  output logic [6:0]      out_duty_second,
  output logic [6:0]      out_duty_zero
);

  logic             s0_valid_r, s1_valid_r, s2_valid_r;
  logic             s0_ready, s1_ready, s2_ready;
  logic [9:0]       angle_r;
  logic [6:0]       mag_r;
  svpwm_pkg::mid_t  mid_nxt, mid_r;
  svpwm_pkg::res_t  res_nxt, res_r;

  // Per-stage ready: take a beat when empty or when draining
  assign s2_ready = !s2_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s0_ready = !s0_valid_r || s1_ready;
  assign in_ready = s0_ready;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s0_ready) s0_valid_r <= in_valid;
      if (s1_ready) s1_valid_r <= s0_valid_r;
      if (s2_ready) s2_valid_r <= s1_valid_r;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (s0_ready && in_valid) begin
      angle_r <= in_angle_deg;
      mag_r   <= in_magnitude_pct;
    end
  end

  svpwm_decode u_decode (
    .angle_deg     (angle_r),
    .magnitude_pct (mag_r),
    .mid           (mid_nxt)
  );

  // Hold the decoded item
  always_ff @(posedge clk) begin
    if (s1_ready && s0_valid_r) begin
      mid_r <= mid_nxt;
    end
  end

  svpwm_duty u_duty (
    .mid (mid_r),
    .res (res_nxt)
  );

  // Hold the result beat
  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  // Drive the result channel
  assign out_valid         = s2_valid_r;
  assign out_sector_code   = res_r.sector_code;
  assign out_first_vector  = res_r.first_vector;
  assign out_second_vector = res_r.second_vector;
  assign out_third_vector  = res_r.third_vector;
  assign out_duty_first    = res_r.duty_first;
  assign out_duty_second   = res_r.duty_second;
  assign out_duty_zero     = res_r.duty_zero;

  // Duties of a delivered beat cover the whole period
  a_duty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (8'(out_duty_first) + 8'(out_duty_second) + 8'(out_duty_zero) == 8'd100))
    else $error("duty shares do not add up to 100");

  // On a vector there is no second vector and no second dwell
  a_on_vector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sector_code < svpwm_pkg::SECTOR_BASE) |->
      (out_second_vector == svpwm_pkg::VEC_NONE && out_duty_second == 7'd0))
    else $error("second vector present while angle lies on a vector");

  // Zero vector is requested exactly when it gets time
  a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_third_vector == svpwm_pkg::VEC_ZERO) == (out_duty_zero != 7'd0)))
    else $error("zero vector code and zero dwell disagree");

  // A decoded beat blocked downstream stays in the decode stage
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> (s1_valid_r && $stable(mid_r)))
    else $error("decode stage lost a stalled beat");

  // A beat in the input stage moves on whenever the decode stage can take it
  a_s0_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && s1_ready) |=> s1_valid_r)
    else $error("input stage beat dropped");

endmodule
`default_nettype wire

/* dv/svpwm_sector_and_duty_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_sector_and_duty_unit_tb
// Self-checking bench for the SVPWM sector decoder and dwell unit. A driver
// sends angle/magnitude beats from a queue, a duty predictor computes the
// expected sector, vectors and duties per accepted beat, and a monitor
// compares every result beat field by field. Sender gaps and receiver
// stalls rotate through several traffic phases.
// ----------------------------------------------------------------------------
module svpwm_sector_and_duty_unit_tb;

  localparam int unsigned SectorSpan  = 60;
  localparam int unsigned NumVectors  = 6;
  localparam int unsigned NumRandom   = 1450;
  localparam int unsigned PhaseBeats  = 150;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HeavyPct    = 76;
  localparam int unsigned LightPct    = 14;

  typedef enum logic [1:0] {
    PH_STEADY,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH
  } traffic_t;

  typedef struct packed {
    logic [9:0] angle;
    logic [6:0] mag;
  } cmd_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [9:0] in_angle_deg = '0;
  logic [6:0] in_magnitude_pct = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_sector_code;
  logic [2:0] out_first_vector;
  logic [2:0] out_second_vector;
  logic [2:0] out_third_vector;
  logic [6:0] out_duty_first;
  logic [6:0] out_duty_second;
  logic [6:0] out_duty_zero;

  cmd_t            cmd_queue[$];
  svpwm_pkg::res_t duty_queue[$];
  int unsigned     total_cmds = 0;
  int unsigned     beats_in = 0;
  int unsigned     cycle_count = 0;
  int unsigned     errors = 0;

  svpwm_sector_and_duty_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_angle_deg      (in_angle_deg),
    .in_magnitude_pct  (in_magnitude_pct),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sector_code   (out_sector_code),
    .out_first_vector  (out_first_vector),
    .out_second_vector (out_second_vector),
    .out_third_vector  (out_third_vector),
    .out_duty_first    (out_duty_first),
    .out_duty_second   (out_duty_second),
    .out_duty_zero     (out_duty_zero)
  );

  // Expected sector, vectors and duty split for one angle/magnitude pair
  function automatic svpwm_pkg::res_t calc_duty(logic [9:0] angle, logic [6:0] mag_in);
    svpwm_pkg::res_t r;
    int unsigned     a;
    int unsigned     m;
    int unsigned     pos;
    int unsigned     share;
    int unsigned     dsec;
    a = angle;
    m = mag_in;
    while (a > svpwm_pkg::FullTurn) a -= svpwm_pkg::FullTurn;
    if (m > svpwm_pkg::FullPct) m = svpwm_pkg::FullPct;
    // 360 folds onto the U+ vector
    if (a == svpwm_pkg::FullTurn) a = 0;
    pos = a / SectorSpan;
    r.third_vector = (m < svpwm_pkg::FullPct) ? svpwm_pkg::VEC_ZERO : svpwm_pkg::VEC_NONE;
    r.duty_zero = 7'(svpwm_pkg::FullPct - m);
    r.first_vector = 3'(svpwm_pkg::VEC_ACTIVE_BASE + pos);
    if (a % SectorSpan == 0) begin
      r.sector_code = 4'(pos);
      r.second_vector = svpwm_pkg::VEC_NONE;
      r.duty_first = 7'(m);
      r.duty_second = '0;
    end else begin
      // round half up of the share of the sector in percent
      share = ((a - pos * SectorSpan) * svpwm_pkg::FullPct + SectorSpan / 2) / SectorSpan;
      dsec = share * m / svpwm_pkg::FullPct;
      r.sector_code = 4'(svpwm_pkg::SECTOR_BASE + pos);
      r.second_vector = 3'(svpwm_pkg::VEC_ACTIVE_BASE + (pos + 1) % NumVectors);
      r.duty_second = 7'(dsec);
      r.duty_first = 7'(m - dsec);
    end
    return r;
  endfunction

  function automatic traffic_t traffic_now(int unsigned n);
    return traffic_t'((n / PhaseBeats) % 4);
  endfunction

  function automatic bit idle_draw(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // Bias angles toward vector positions, sector edges and the turn wrap
  function automatic logic [9:0] pick_angle();
    int unsigned k;
    k = $urandom_range(17);
    case ($urandom_range(9))
      0, 1: return 10'(k * SectorSpan);
      2: return 10'(k * SectorSpan + 1);
      3: return 10'(k * SectorSpan - 1);
      4: return 10'(($urandom_range(1) + 1) * svpwm_pkg::FullTurn - 1 + $urandom_range(2));
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  function automatic logic [6:0] pick_mag();
    case ($urandom_range(7))
      0: return '0;
      1: return svpwm_pkg::FullPct;
      2: return 7'($urandom_range(127, 101));
      3: return 7'(svpwm_pkg::FullPct - 1);
      default: return 7'($urandom_range(svpwm_pkg::FullPct));
    endcase
  endfunction

  task automatic push_cmd(logic [9:0] angle, logic [6:0] mag);
    cmd_t cmd;
    cmd.angle = angle;
    cmd.mag = mag;
    cmd_queue.push_back(cmd);
  endtask

  task automatic check_field(string name, logic [6:0] want, logic [6:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Run the clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Fill the command queue, release reset, wait for the drain
  initial begin
    int unsigned i;
    push_cmd(10'd0, 7'd0);
    push_cmd(10'd1023, 7'd127);
    push_cmd(10'd360, 7'd50);
    push_cmd(10'd361, 7'd50);
    push_cmd(10'd720, 7'd100);
    push_cmd(10'd721, 7'd99);
    push_cmd(10'd60, 7'd100);
    push_cmd(10'd120, 7'd1);
    push_cmd(10'd180, 7'd101);
    push_cmd(10'd240, 7'd73);
    push_cmd(10'd300, 7'd50);
    push_cmd(10'd359, 7'd100);
    push_cmd(10'd1, 7'd100);
    push_cmd(10'd59, 7'd100);
    push_cmd(10'd30, 7'd100);
    push_cmd(10'd90, 7'd127);
    push_cmd(10'd150, 7'd64);
    push_cmd(10'd210, 7'd37);
    push_cmd(10'd270, 7'd85);
    push_cmd(10'd330, 7'd100);
    push_cmd(10'd1020, 7'd127);
    push_cmd(10'd719, 7'd64);
    push_cmd(10'd420, 7'd37);
    push_cmd(10'd0, 7'd100);
    for (i = 0; i < NumRandom; i++) begin
      push_cmd(pick_angle(), pick_mag());
    end
    total_cmds = cmd_queue.size();

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_in != total_cmds) @(posedge clk);
    while (duty_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Drive command beats; hold valid and payload until accepted
  always @(posedge clk) begin
    cmd_t     cmd;
    traffic_t ph;
    bit       send_gap;
    ph = traffic_now(beats_in);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        duty_queue.push_back(calc_duty(in_angle_deg, in_magnitude_pct));
        beats_in <= beats_in + 1;
      end
      if (!in_valid || in_ready) begin
        case (ph)
          PH_SEND_IDLE: send_gap = idle_draw(HeavyPct);
          PH_BOTH:      send_gap = idle_draw(LightPct);
          default:      send_gap = 1'b0;
        endcase
        if (cmd_queue.size() > 0 && !send_gap) begin
          cmd = cmd_queue.pop_front();
          in_valid <= 1'b1;
          in_angle_deg <= cmd.angle;
          in_magnitude_pct <= cmd.mag;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result channel and check each accepted result beat
  always @(posedge clk) begin
    svpwm_pkg::res_t want;
    traffic_t        ph;
    ph = traffic_now(beats_in);
    case (ph)
      PH_RECV_STALL: out_ready <= !idle_draw(HeavyPct);
      PH_BOTH:       out_ready <= !idle_draw(LightPct);
      default:       out_ready <= 1'b1;
    endcase
    if (rst_n && out_valid && out_ready) begin
      if (duty_queue.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual sector %0d",
                 $time, out_sector_code);
        errors++;
      end else begin
        want = duty_queue.pop_front();
        check_field("sector_code", 7'(want.sector_code), 7'(out_sector_code));
        check_field("first_vector", 7'(want.first_vector), 7'(out_first_vector));
        check_field("second_vector", 7'(want.second_vector), 7'(out_second_vector));
        check_field("third_vector", 7'(want.third_vector), 7'(out_third_vector));
        check_field("duty_first", want.duty_first, out_duty_first);
        check_field("duty_second", want.duty_second, out_duty_second);
        check_field("duty_zero", want.duty_zero, out_duty_zero);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d results outstanding", $time, duty_queue.size());
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

/* sim.f */
rtl/core/svpwm_pkg.sv
rtl/core/svpwm_decode.sv
rtl/core/svpwm_duty.sv
rtl/core/svpwm_sector_and_duty_unit.sv
dv/svpwm_sector_and_duty_unit_tb.sv
